// ----- rtl/core/crc16_delimited_frame_encoder_unit_macros.svh -----
// assertion macros shared by the frame encoder files
`ifndef CRC16_DELIMITED_FRAME_ENCODER_UNIT_MACROS_SVH
`define CRC16_DELIMITED_FRAME_ENCODER_UNIT_MACROS_SVH

// same-cycle implication
`define CRCDFE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CRCDFE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/crcdfe_pkg.sv -----
package crcdfe_pkg;

   localparam int BYTE_W      = 8;
   localparam int CRC_W       = 16;
   localparam int MAX_BURST   = 5;
   localparam int BURST_CNT_W = $clog2(MAX_BURST + 1);
   localparam int CSR_INDEX_W = 8;

   localparam logic [CRC_W-1:0]  CRC_POLY    = 16'h1021;
   localparam logic [CRC_W-1:0]  CRC_INIT    = 16'h0000;
   localparam logic [CRC_W-1:0]  CRC_TOP_BIT = 16'h8000;
   localparam logic [BYTE_W-1:0] START_RESET = 8'h7e;
   localparam logic [BYTE_W-1:0] END_RESET   = 8'h7f;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_DELIM = 8'd0,
      CSR_END_DELIM   = 8'd1
   } csr_index_type;

   // burst of line bytes handed to the output buffer, entry 0 goes first
   typedef struct packed {
      logic                               valid;
      logic [BURST_CNT_W-1:0]             count;
      logic [MAX_BURST-1:0][BYTE_W-1:0]   bytes;
   } burst_type;

   // bytewise crc-16/xmodem update, msb first
   function automatic logic [CRC_W-1:0] crc_add_byte(input logic [CRC_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {data, {(CRC_W - BYTE_W){1'b0}}};
      for (int k = 0; k < BYTE_W; k++) begin
         if ((c & CRC_TOP_BIT) != '0) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ----- rtl/core/crcdfe_burst_buffer.sv -----
`include "crc16_delimited_frame_encoder_unit_macros.svh"

module crcdfe_burst_buffer (
   input  logic                            clock,
   input  logic                            reset,
   input  crcdfe_pkg::burst_type           load,
   input  logic                            take,
   output logic                            free,
   output logic                            head_valid,
   output logic [crcdfe_pkg::BYTE_W-1:0]   head_byte,
   output logic                            head_last
);

   logic [crcdfe_pkg::BURST_CNT_W-1:0]                       count_ff, count_in;
   logic [crcdfe_pkg::MAX_BURST-1:0][crcdfe_pkg::BYTE_W-1:0] bytes_ff, bytes_in;

   // head of the burst drives the output beat
   assign head_valid = (count_ff != '0);
   assign head_byte  = bytes_ff[0];
   assign head_last  = (count_ff == crcdfe_pkg::BURST_CNT_W'(1));
   assign free       = (count_ff == '0) || (head_last && take);

   // load a new burst or shift out one byte per taken beat
   always_comb begin
      count_in = count_ff;
      bytes_in = bytes_ff;
      if (load.valid) begin
         count_in = load.count;
         bytes_in = load.bytes;
      end else if (head_valid && take) begin
         count_in = count_ff - crcdfe_pkg::BURST_CNT_W'(1);
         for (int i = 0; i < crcdfe_pkg::MAX_BURST - 1; i++) begin
            bytes_in[i] = bytes_ff[i+1];
         end
         bytes_in[crcdfe_pkg::MAX_BURST-1] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      bytes_ff <= bytes_in;
   end

   `CRCDFE_ASSERT_NOW(a_load_only_when_free, clock, reset, load.valid, free, "burst loaded over pending bytes")
   `CRCDFE_ASSERT_NOW(a_count_in_range, clock, reset, 1'b1, count_ff <= crcdfe_pkg::BURST_CNT_W'(crcdfe_pkg::MAX_BURST), "burst count out of range")
   `CRCDFE_ASSERT_NEXT(a_stalled_head_holds, clock, reset, head_valid && !take, $stable(head_byte) && $stable(count_ff), "stalled beat changed")

endmodule

// ----- rtl/core/crc16_delimited_frame_encoder_unit.sv -----
// Frame encoder with CRC-16/XMODEM trailer. Payload bytes arrive one per beat
// on req_, with req_tlast on the final byte of a frame. The first byte of a
// frame goes out behind the start delimiter; after the last byte come the CRC
// (poly 0x1021, init 0, high byte first) and the end delimiter. Each input
// beat yields one to five output beats, and rsp_tlast marks the last of them.
// A middle byte yields one output beat and a one-byte frame five. The output
// side moves one byte per cycle while rsp_tready is high. An accepted beat
// sits in an input register and, once the output burst register is free, is
// expanded into a byte burst with the CRC update and loaded there, and its
// first output byte is shown from that register. A new beat can be taken into
// the input register while the previous burst is still draining, but waits
// there until the burst register is free. Delimiter writes on csr_ are taken
// every cycle and are used by beats expanded after the write.
`include "crc16_delimited_frame_encoder_unit_macros.svh"

module crc16_delimited_frame_encoder_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [crcdfe_pkg::BYTE_W-1:0]        req_tdata,   // [7:0] payload_byte
   input  logic                                 req_tlast,   // frame_last
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [crcdfe_pkg::BYTE_W-1:0]        rsp_tdata,   // [7:0] line_byte
   output logic                                 rsp_tlast,   // run_last
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [crcdfe_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [crcdfe_pkg::BYTE_W-1:0]        csr_data
);

   logic                              s1_valid_ff, s1_valid_in;
   logic [crcdfe_pkg::BYTE_W-1:0]     s1_byte_ff, s1_byte_in;
   logic                              s1_last_ff, s1_last_in;
   logic                              inside_ff, inside_in;
   logic [crcdfe_pkg::CRC_W-1:0]      crc_ff, crc_in;
   logic [crcdfe_pkg::BYTE_W-1:0]     start_delim_ff, start_delim_in;
   logic [crcdfe_pkg::BYTE_W-1:0]     end_delim_ff, end_delim_in;
   logic [crcdfe_pkg::CRC_W-1:0]      crc_next;
   logic                              s1_move;
   logic                              buf_free;
   crcdfe_pkg::burst_type             burst;

   assign csr_ready  = 1'b1;
   assign s1_move    = s1_valid_ff && buf_free;
   assign req_tready = !s1_valid_ff || s1_move;

   // delimiter registers
   always_comb begin
      start_delim_in = start_delim_ff;
      end_delim_in   = end_delim_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == crcdfe_pkg::CSR_START_DELIM) begin
            start_delim_in = csr_data;
         end else if (csr_index == crcdfe_pkg::CSR_END_DELIM) begin
            end_delim_in = csr_data;
         end
      end
   end

   // input register
   always_comb begin
      s1_valid_in = s1_valid_ff && !s1_move;
      s1_byte_in  = s1_byte_ff;
      s1_last_in  = s1_last_ff;
      if (req_tvalid && req_tready) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_tdata;
         s1_last_in  = req_tlast;
      end
   end

   // crc update, restarting at a frame's first byte
   assign crc_next = crcdfe_pkg::crc_add_byte(inside_ff ? crc_ff : crcdfe_pkg::CRC_INIT,
                                              s1_byte_ff);

   // frame state
   always_comb begin
      inside_in = inside_ff;
      crc_in    = crc_ff;
      if (s1_move) begin
         if (s1_last_ff) begin
            inside_in = 1'b0;
            crc_in    = crcdfe_pkg::CRC_INIT;
         end else begin
            inside_in = 1'b1;
            crc_in    = crc_next;
         end
      end
   end

   // expand the item into its burst of line bytes
   always_comb begin
      burst       = '0;
      burst.valid = s1_move;
      if (!inside_ff) begin
         burst.bytes[0] = start_delim_ff;
         burst.bytes[1] = s1_byte_ff;
         if (s1_last_ff) begin
            burst.bytes[2] = crc_next[15:8];
            burst.bytes[3] = crc_next[7:0];
            burst.bytes[4] = end_delim_ff;
            burst.count    = crcdfe_pkg::BURST_CNT_W'(5);
         end else begin
            burst.count    = crcdfe_pkg::BURST_CNT_W'(2);
         end
      end else begin
         burst.bytes[0] = s1_byte_ff;
         if (s1_last_ff) begin
            burst.bytes[1] = crc_next[15:8];
            burst.bytes[2] = crc_next[7:0];
            burst.bytes[3] = end_delim_ff;
            burst.count    = crcdfe_pkg::BURST_CNT_W'(4);
         end else begin
            burst.count    = crcdfe_pkg::BURST_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         inside_ff      <= 1'b0;
         crc_ff         <= crcdfe_pkg::CRC_INIT;
         start_delim_ff <= crcdfe_pkg::START_RESET;
         end_delim_ff   <= crcdfe_pkg::END_RESET;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         inside_ff      <= inside_in;
         crc_ff         <= crc_in;
         start_delim_ff <= start_delim_in;
         end_delim_ff   <= end_delim_in;
      end
      s1_byte_ff <= s1_byte_in;
      s1_last_ff <= s1_last_in;
   end

   // output burst register
   crcdfe_burst_buffer u_burst_buffer (
      .clock      (clock),
      .reset      (reset),
      .load       (burst),
      .take       (rsp_tready),
      .free       (buf_free),
      .head_valid (rsp_tvalid),
      .head_byte  (rsp_tdata),
      .head_last  (rsp_tlast)
   );

   `CRCDFE_ASSERT_NOW(a_crc_idle_outside_frame, clock, reset, !inside_ff, crc_ff == crcdfe_pkg::CRC_INIT, "crc not cleared outside a frame")
   `CRCDFE_ASSERT_NEXT(a_frame_closes, clock, reset, s1_move && s1_last_ff, !inside_ff, "frame still open after its last byte")
   `CRCDFE_ASSERT_NEXT(a_burst_shown, clock, reset, s1_move, rsp_tvalid, "expanded item shows no beat")

endmodule
